FILE: hdl/preemptive_priority_scheduler_macros.svh
// Assertion macros for the preemptive priority scheduler.
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_MACROS_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define PPS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled in reset.
`define PPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/pps_pkg.sv
// Shared types and codes for the preemptive priority scheduler.
`default_nettype none

package pps_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIND,
    ST_SCAN,
    ST_DRAIN,
    ST_TICK,
    ST_WAIT
  } state_t;

  localparam logic KIND_ARRIVE = 1'b0;
  localparam logic KIND_TICK   = 1'b1;

  localparam logic [2:0] STAT_ACCEPT = 3'd0;
  localparam logic [2:0] STAT_FULL   = 3'd1;
  localparam logic [2:0] STAT_IDLE   = 3'd2;
  localparam logic [2:0] STAT_RAN    = 3'd3;
  localparam logic [2:0] STAT_DONE   = 3'd4;

  typedef struct packed {
    logic [7:0]  id;
    logic [7:0]  prio;
    logic [31:0] arrival;
    logic [15:0] burst;
    logic [15:0] left;
  } slot_t;

endpackage

`default_nettype wire

FILE: hdl/preemptive_priority_scheduler.sv
// Top level of the preemptive priority scheduler: sequencer, slot table, clock.
//
// channel  ports                                   transfer
// input    start/busy, in_kind..in_burst           start high while busy low
// result   out_valid, out_status..out_waiting      out_valid high, one cycle
//
// Arrival: the free slot is searched one valid bit per cycle.
// Tick: the slot memory is scanned one entry per cycle through its single read
// port, then the DRAIN, TICK and (on completion) WAIT states follow.
// Reset (rst_n low, synchronous) empties the table and zeroes the tick count.
// The receiver cannot stall; each result is strobed once.
`default_nettype none

`include "preemptive_priority_scheduler_macros.svh"

module preemptive_priority_scheduler #(
  parameter int SLOTS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_kind,
  input  wire logic [7:0]  in_task_id,
  input  wire logic [7:0]  in_prio,
  input  wire logic [15:0] in_burst,
  output logic             out_valid,
  output logic [2:0]       out_status,
  output logic [7:0]       out_ran_id,
  output logic [31:0]      out_finish_time,
  output logic [31:0]      out_turnaround,
  output logic [31:0]      out_waiting
);

  localparam int IW = $clog2(SLOTS);
  localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

  pps_pkg::state_t state_r, state_nxt;
  logic [SLOTS-1:0] valid_r, valid_nxt;
  logic [31:0]      now_r, now_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             cmp_vld_r, cmp_vld_nxt;
  logic             best_found_r, best_found_nxt;

  logic [IW-1:0]    idx_r, idx_nxt;
  logic [IW-1:0]    cmp_idx_r, cmp_idx_nxt;
  logic [IW-1:0]    best_idx_r, best_idx_nxt;
  pps_pkg::slot_t   best_r, best_nxt;

  logic [7:0]       req_id_r, req_id_nxt;
  logic [7:0]       req_prio_r, req_prio_nxt;
  logic [15:0]      req_burst_r, req_burst_nxt;

  logic [2:0]       res_status_r, res_status_nxt;
  logic [7:0]       res_id_r, res_id_nxt;
  logic [31:0]      res_fin_r, res_fin_nxt;
  logic [31:0]      res_tat_r, res_tat_nxt;
  logic [31:0]      res_wt_r, res_wt_nxt;

  logic             wr_en, rd_en, take;
  logic [IW-1:0]    wr_addr;
  pps_pkg::slot_t   wr_data, rd_data;

  pps_slot_mem #(.SLOTS(SLOTS)) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (idx_r),
    .rd_data (rd_data)
  );

  pps_cmp u_cmp (
    .cand_valid   (cmp_vld_r && valid_r[cmp_idx_r]),
    .cand_prio    (rd_data.prio),
    .cand_arrival (rd_data.arrival),
    .best_found   (best_found_r),
    .best_prio    (best_r.prio),
    .best_arrival (best_r.arrival),
    .take         (take)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= pps_pkg::ST_IDLE;
      valid_r      <= '0;
      now_r        <= '0;
      out_valid_r  <= 1'b0;
      cmp_vld_r    <= 1'b0;
      best_found_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      valid_r      <= valid_nxt;
      now_r        <= now_nxt;
      out_valid_r  <= out_valid_nxt;
      cmp_vld_r    <= cmp_vld_nxt;
      best_found_r <= best_found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    best_idx_r   <= best_idx_nxt;
    best_r       <= best_nxt;
    req_id_r     <= req_id_nxt;
    req_prio_r   <= req_prio_nxt;
    req_burst_r  <= req_burst_nxt;
    res_status_r <= res_status_nxt;
    res_id_r     <= res_id_nxt;
    res_fin_r    <= res_fin_nxt;
    res_tat_r    <= res_tat_nxt;
    res_wt_r     <= res_wt_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    valid_nxt      = valid_r;
    now_nxt        = now_r;
    out_valid_nxt  = 1'b0;
    cmp_vld_nxt    = 1'b0;
    best_found_nxt = best_found_r;
    idx_nxt        = idx_r;
    cmp_idx_nxt    = cmp_idx_r;
    best_idx_nxt   = best_idx_r;
    best_nxt       = best_r;
    req_id_nxt     = req_id_r;
    req_prio_nxt   = req_prio_r;
    req_burst_nxt  = req_burst_r;
    res_status_nxt = res_status_r;
    res_id_nxt     = res_id_r;
    res_fin_nxt    = res_fin_r;
    res_tat_nxt    = res_tat_r;
    res_wt_nxt     = res_wt_r;
    wr_en          = 1'b0;
    wr_addr        = idx_r;
    wr_data        = best_r;
    rd_en          = 1'b0;

    // fold the slot read last cycle into the running best
    if (cmp_vld_r && take) begin
      best_found_nxt = 1'b1;
      best_idx_nxt   = cmp_idx_r;
      best_nxt       = rd_data;
    end

    case (state_r)
      pps_pkg::ST_IDLE: begin
        if (start) begin
          req_id_nxt     = in_task_id;
          req_prio_nxt   = in_prio;
          req_burst_nxt  = in_burst;
          idx_nxt        = '0;
          best_found_nxt = 1'b0;
          state_nxt      = (in_kind == pps_pkg::KIND_TICK) ? pps_pkg::ST_SCAN
                                                           : pps_pkg::ST_FIND;
        end
      end
      pps_pkg::ST_FIND: begin
        res_id_nxt  = req_id_r;
        res_fin_nxt = now_r;
        res_tat_nxt = '0;
        res_wt_nxt  = '0;
        if (!valid_r[idx_r]) begin
          wr_en              = 1'b1;
          wr_data.id         = req_id_r;
          wr_data.prio       = req_prio_r;
          wr_data.arrival    = now_r;
          wr_data.burst      = req_burst_r;
          wr_data.left       = req_burst_r;
          valid_nxt[idx_r]   = 1'b1;
          res_status_nxt     = pps_pkg::STAT_ACCEPT;
          out_valid_nxt      = 1'b1;
          state_nxt          = pps_pkg::ST_IDLE;
        end else if (idx_r == LAST) begin
          res_status_nxt = pps_pkg::STAT_FULL;
          out_valid_nxt  = 1'b1;
          state_nxt      = pps_pkg::ST_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      pps_pkg::ST_SCAN: begin
        rd_en       = 1'b1;
        cmp_vld_nxt = 1'b1;
        cmp_idx_nxt = idx_r;
        if (idx_r == LAST) begin
          state_nxt = pps_pkg::ST_DRAIN;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      pps_pkg::ST_DRAIN: begin
        now_nxt   = now_r + 32'd1;
        state_nxt = pps_pkg::ST_TICK;
      end
      pps_pkg::ST_TICK: begin
        res_fin_nxt = now_r;
        res_tat_nxt = '0;
        res_wt_nxt  = '0;
        if (!best_found_r) begin
          res_status_nxt = pps_pkg::STAT_IDLE;
          res_id_nxt     = '0;
          out_valid_nxt  = 1'b1;
          state_nxt      = pps_pkg::ST_IDLE;
        end else if (best_r.left <= 16'd1) begin
          valid_nxt[best_idx_r] = 1'b0;
          res_status_nxt        = pps_pkg::STAT_DONE;
          res_id_nxt            = best_r.id;
          res_tat_nxt           = now_r - best_r.arrival;
          state_nxt             = pps_pkg::ST_WAIT;
        end else begin
          wr_en          = 1'b1;
          wr_addr        = best_idx_r;
          wr_data.left   = best_r.left - 16'd1;
          res_status_nxt = pps_pkg::STAT_RAN;
          res_id_nxt     = best_r.id;
          out_valid_nxt  = 1'b1;
          state_nxt      = pps_pkg::ST_IDLE;
        end
      end
      pps_pkg::ST_WAIT: begin
        res_wt_nxt    = res_tat_r - {16'd0, best_r.burst};
        out_valid_nxt = 1'b1;
        state_nxt     = pps_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = pps_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy            = (state_r != pps_pkg::ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = res_status_r;
  assign out_ran_id      = res_id_r;
  assign out_finish_time = res_fin_r;
  assign out_turnaround  = res_tat_r;
  assign out_waiting     = res_wt_r;

  `PPS_ASSERT_NEXT(a_strobe_single, out_valid_r, !out_valid_r, "result strobe held two cycles")
  `PPS_ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted transfer did not raise busy")
  `PPS_ASSERT_NEXT(a_scan_stable, state_r == pps_pkg::ST_SCAN, $stable(valid_r), "slot table changed during scan")
  `PPS_ASSERT_NOW(a_idle_zero, out_valid_r && (res_status_r == pps_pkg::STAT_IDLE), (res_id_r == 8'd0) && (res_tat_r == 32'd0), "idle tick carries task data")

endmodule

`default_nettype wire

FILE: hdl/pps_slot_mem.sv
// Task slot memory: one write port, one registered read port.
`default_nettype none

module pps_slot_mem #(
  parameter int SLOTS = 16
) (
  input  wire logic                       clk,
  input  wire logic                       wr_en,
  input  wire logic [$clog2(SLOTS)-1:0]   wr_addr,
  input  wire pps_pkg::slot_t             wr_data,
  input  wire logic                       rd_en,
  input  wire logic [$clog2(SLOTS)-1:0]   rd_addr,
  output pps_pkg::slot_t                  rd_data
);

  pps_pkg::slot_t mem [SLOTS];
  pps_pkg::slot_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

FILE: hdl/pps_cmp.sv
// Shared compare unit: does the scanned slot beat the best so far.
`default_nettype none

module pps_cmp (
  input  wire logic        cand_valid,
  input  wire logic [7:0]  cand_prio,
  input  wire logic [31:0] cand_arrival,
  input  wire logic        best_found,
  input  wire logic [7:0]  best_prio,
  input  wire logic [31:0] best_arrival,
  output logic             take
);

  logic better;

  // candidate always has the higher slot index, so a full tie keeps the best
  always_comb begin
    if (cand_prio != best_prio) begin
      better = cand_prio > best_prio;
    end else begin
      better = cand_arrival < best_arrival;
    end
    take = cand_valid && (!best_found || better);
  end

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
// Testbench for the preemptive priority scheduler: directed table, then random traffic.
`timescale 1ns / 1ps

module tb_top;

  localparam int SLOTS       = 16;
  localparam int DIR_COUNT   = 19;
  localparam int PHASE_ITEMS = 344;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_WAIT  = 40;

  typedef struct packed {
    logic        kind;
    logic [7:0]  task_id;
    logic [7:0]  prio;
    logic [15:0] burst;
  } sched_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  ran_id;
    logic [31:0] finish_time;
    logic [31:0] turnaround;
    logic [31:0] waiting;
  } sched_result_t;

  typedef struct packed {
    sched_item_t   item;
    logic          typed;
    sched_result_t want;
  } dir_row_t;

  localparam dir_row_t DIR_ROWS [DIR_COUNT] = '{
    '{'{pps_pkg::KIND_TICK,   8'h00, 8'h00, 16'h0000}, 1'b1,
      '{pps_pkg::STAT_IDLE,   8'h00, 32'd1, 32'd0, 32'd0}},
    '{'{pps_pkg::KIND_ARRIVE, 8'h00, 8'h00, 16'hFFFF}, 1'b1,
      '{pps_pkg::STAT_ACCEPT, 8'h00, 32'd1, 32'd0, 32'd0}},
    '{'{pps_pkg::KIND_ARRIVE, 8'hFF, 8'hFF, 16'h0001}, 1'b1,
      '{pps_pkg::STAT_ACCEPT, 8'hFF, 32'd1, 32'd0, 32'd0}},
    '{'{pps_pkg::KIND_TICK,   8'h00, 8'h00, 16'h0000}, 1'b1,
      '{pps_pkg::STAT_DONE,   8'hFF, 32'd2, 32'd1, 32'd0}},
    '{'{pps_pkg::KIND_ARRIVE, 8'h11, 8'h80, 16'h0000}, 1'b1,
      '{pps_pkg::STAT_ACCEPT, 8'h11, 32'd2, 32'd0, 32'd0}},
    '{'{pps_pkg::KIND_TICK,   8'h00, 8'h00, 16'h0000}, 1'b0, '0},
    '{'{pps_pkg::KIND_ARRIVE, 8'h21, 8'h40, 16'h0002}, 1'b0, '0},
    '{'{pps_pkg::KIND_ARRIVE, 8'h22, 8'h40, 16'h0002}, 1'b0, '0},
    '{'{pps_pkg::KIND_TICK,   8'h00, 8'h00, 16'h0000}, 1'b0, '0},
    '{'{pps_pkg::KIND_TICK,   8'h00, 8'h00, 16'h0000}, 1'b0, '0},
    '{'{pps_pkg::KIND_ARRIVE, 8'h23, 8'h40, 16'h0001}, 1'b0, '0},
    '{'{pps_pkg::KIND_TICK,   8'h00, 8'h00, 16'h0000}, 1'b0, '0},
    '{'{pps_pkg::KIND_TICK,   8'h00, 8'h00, 16'h0000}, 1'b0, '0},
    '{'{pps_pkg::KIND_TICK,   8'h00, 8'h00, 16'h0000}, 1'b0, '0},
    '{'{pps_pkg::KIND_TICK,   8'hFF, 8'hFF, 16'hFFFF}, 1'b0, '0},
    '{'{pps_pkg::KIND_ARRIVE, 8'h5A, 8'hA5, 16'h0003}, 1'b0, '0},
    '{'{pps_pkg::KIND_TICK,   8'h00, 8'h00, 16'h0000}, 1'b0, '0},
    '{'{pps_pkg::KIND_TICK,   8'h00, 8'h00, 16'h0000}, 1'b0, '0},
    '{'{pps_pkg::KIND_TICK,   8'h00, 8'h00, 16'h0000}, 1'b0, '0}
  };

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_kind;
  logic [7:0]  in_task_id;
  logic [7:0]  in_prio;
  logic [15:0] in_burst;
  logic        out_valid;
  logic [2:0]  out_status;
  logic [7:0]  out_ran_id;
  logic [31:0] out_finish_time;
  logic [31:0] out_turnaround;
  logic [31:0] out_waiting;

  logic            slot_valid [SLOTS];
  pps_pkg::slot_t  slots [SLOTS];
  logic [31:0]     now_tick;

  sched_result_t due_results [$];
  int          fail_count;
  int          stall_cycles;
  int          idle_pct;

  preemptive_priority_scheduler #(.SLOTS(SLOTS)) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_kind         (in_kind),
    .in_task_id      (in_task_id),
    .in_prio         (in_prio),
    .in_burst        (in_burst),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_ran_id      (out_ran_id),
    .out_finish_time (out_finish_time),
    .out_turnaround  (out_turnaround),
    .out_waiting     (out_waiting)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic sched_result_t schedule_step(input sched_item_t it);
    sched_result_t r;
    int pick;
    r = '0;
    pick = -1;
    if (it.kind == pps_pkg::KIND_ARRIVE) begin
      r.status = pps_pkg::STAT_FULL;
      r.ran_id = it.task_id;
      r.finish_time = now_tick;
      for (int s = 0; s < SLOTS && r.status == pps_pkg::STAT_FULL; s++) begin
        if (!slot_valid[s]) begin
          slot_valid[s] = 1'b1;
          slots[s] = '{it.task_id, it.prio, now_tick, it.burst, it.burst};
          r.status = pps_pkg::STAT_ACCEPT;
        end
      end
    end else begin
      // strict compares keep the lowest slot on a full tie
      for (int s = 0; s < SLOTS; s++) begin
        if (slot_valid[s] && (pick < 0 || slots[s].prio > slots[pick].prio ||
            (slots[s].prio == slots[pick].prio &&
             slots[s].arrival < slots[pick].arrival)))
          pick = s;
      end
      now_tick = now_tick + 32'd1;
      r.finish_time = now_tick;
      if (pick < 0) begin
        r.status = pps_pkg::STAT_IDLE;
      end else begin
        r.ran_id = slots[pick].id;
        if (slots[pick].left <= 16'd1) begin
          r.status = pps_pkg::STAT_DONE;
          r.turnaround = now_tick - slots[pick].arrival;
          r.waiting = r.turnaround - 32'(slots[pick].burst);
          slots[pick].left = '0;
          slot_valid[pick] = 1'b0;
        end else begin
          r.status = pps_pkg::STAT_RAN;
          slots[pick].left = slots[pick].left - 16'd1;
        end
      end
    end
    return r;
  endfunction

  function automatic sched_item_t random_item(input int arrive_pct);
    sched_item_t it;
    int roll;
    it.kind = ($urandom_range(99) < arrive_pct) ? pps_pkg::KIND_ARRIVE : pps_pkg::KIND_TICK;
    it.task_id = 8'($urandom);
    // prio 0 stays out: the long directed task would starve it forever
    it.prio = $urandom_range(1) ? 8'($urandom_range(255, 1)) : 8'($urandom_range(3, 1));
    roll = $urandom_range(99);
    if (roll < 70)
      it.burst = 16'($urandom_range(4, 1));
    else if (roll < 95)
      it.burst = 16'($urandom_range(24, 5));
    else
      it.burst = 16'($urandom_range(200, 25));
    return it;
  endfunction

  task automatic send_item(input sched_item_t it, input logic typed, input sched_result_t want);
    sched_result_t r;
    @(negedge clk);
    start      <= 1'b1;
    in_kind    <= it.kind;
    in_task_id <= it.task_id;
    in_prio    <= it.prio;
    in_burst   <= it.burst;
    do @(posedge clk); while (busy);
    r = schedule_step(it);
    due_results.push_back(typed ? want : r);
  endtask

  task automatic wait_results_done();
    @(negedge clk);
    start <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
  endtask

  function automatic int field_bad(input string name, input logic [31:0] want,
                                   input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    sched_result_t want;
    if (rst_n && out_valid) begin
      if (due_results.size() == 0) begin
        $error("unexpected result: status %0d, ran_id %0d", out_status, out_ran_id);
        fail_count = fail_count + 1;
      end else begin
        want = due_results.pop_front();
        fail_count = fail_count + field_bad("status", 32'(want.status), 32'(out_status))
                   + field_bad("ran_id", 32'(want.ran_id), 32'(out_ran_id))
                   + field_bad("finish_time", want.finish_time, out_finish_time)
                   + field_bad("turnaround", want.turnaround, out_turnaround)
                   + field_bad("waiting", want.waiting, out_waiting);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    sched_item_t it;
    int arrive_pct;
    int run_left;
    int phase_idle [3];
    phase_idle = '{17, 77, 0};
    fail_count   = 0;
    stall_cycles = 0;
    arrive_pct   = 50;
    run_left     = 0;
    rst_n      = 1'b0;
    start      = 1'b0;
    in_kind    = pps_pkg::KIND_ARRIVE;
    in_task_id = '0;
    in_prio    = '0;
    in_burst   = '0;
    now_tick   = '0;
    foreach (slot_valid[s]) begin
      slot_valid[s] = 1'b0;
      slots[s] = '0;
    end
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int n = 0; n < DIR_COUNT; n++)
      send_item(DIR_ROWS[n].item, DIR_ROWS[n].typed, DIR_ROWS[n].want);

    for (int ph = 0; ph < 3; ph++) begin
      wait_results_done();
      idle_pct = phase_idle[ph];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // alternate fill, drain and mixed runs so the table fills and empties
        if (run_left == 0) begin
          case ($urandom_range(2))
            0: arrive_pct = 85;
            1: arrive_pct = 10;
            default: arrive_pct = 45;
          endcase
          run_left = $urandom_range(40, 8);
        end
        run_left = run_left - 1;
        it = random_item(arrive_pct);
        if ($urandom_range(99) < idle_pct) begin
          @(negedge clk);
          start <= 1'b0;
          repeat ($urandom_range(3)) @(negedge clk);
        end
        send_item(it, 1'b0, '0);
      end
    end

    wait_results_done();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0 && due_results.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
